/* sv/rmq_pkg.sv */
`default_nettype none

package rmq_pkg;

    // Which quaternion slot receives s/2 (the dominant component).
    typedef enum logic [1:0] {
        PATH_X,
        PATH_Y,
        PATH_Z,
        PATH_W
    } path_t;

    localparam int DIFF_W = 17;

    // Side information that rides along the square root chain.
    typedef struct packed {
        logic                       invalid;
        path_t                      path;
        logic signed [DIFF_W-1:0]   d0;
        logic signed [DIFF_W-1:0]   d1;
        logic signed [DIFF_W-1:0]   d2;
    } rmq_ctl_t;

    // Side information that rides along the divider chain.
    typedef struct packed {
        logic       invalid;
        path_t      path;
        logic [2:0] neg;
    } rmq_sign_t;

endpackage

`default_nettype wire

/* sv/rotation_matrix_to_quaternion.sv */
// Stages: a front register, SW = (32 + FRAC_BITS) / 2 root cells,
// QW = 17 + FRAC_BITS divider cells and an output register.
// Throughput: one request per cycle; the whole chain advances together and
// halts only while the output register holds a result that is not taken.
// Reset: rst_n is asynchronous and active low; it clears every stage valid
// bit, so the block comes out of reset empty and ready.
`default_nettype none

// Shepperd's method in fixed point. A front stage forms the trace, picks the
// branch and builds the radicand and the three numerators. A chain of root
// cells then produces one bit of s = floor(sqrt(rad << FRAC_BITS)) per
// cycle, and a chain of divider cells produces one quotient bit per cycle for
// the three numerators at once, each divided by 2s, while not halted. The
// last stage applies signs, saturates, and places the components by branch.
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] r00,
    input  wire logic signed [15:0] r01,
    input  wire logic signed [15:0] r02,
    input  wire logic signed [15:0] r10,
    input  wire logic signed [15:0] r11,
    input  wire logic signed [15:0] r12,
    input  wire logic signed [15:0] r20,
    input  wire logic signed [15:0] r21,
    input  wire logic signed [15:0] r22,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      quat_x,
    output logic signed [15:0]      quat_y,
    output logic signed [15:0]      quat_z,
    output logic signed [15:0]      quat_w,
    output logic                    invalid
);
    import rmq_pkg::*;

    // Root width: the radicand is below 2^31, so rad << FRAC_BITS fits 2*SW bits.
    localparam int SW = (32 + FRAC_BITS) / 2;
    localparam int NW = 2 * SW;
    // Divisor 2s and numerator magnitude |d| << FRAC_BITS.
    localparam int DW = SW + 1;
    localparam int QW = DIFF_W + FRAC_BITS;
    localparam int SAT_LIM = (FRAC_BITS < 15) ? (1 << FRAC_BITS) : 32767;
    localparam logic signed [31:0] ONE_Q = 32'(64'd1 << FRAC_BITS);

    // The whole chain moves whenever the output register can take a result.
    logic en;
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // ------------------------------------------------------------------
    // Front stage: branch selection, radicand and numerators.
    // ------------------------------------------------------------------
    logic signed [17:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    logic signed [17:0] trace;
    logic signed [17:0] rsum;
    logic signed [31:0] rad;
    logic signed [17:0] t0, t1, t2;
    path_t              path;
    rmq_ctl_t           ctl_front;
    logic [NW-1:0]      n_front;

    always_comb
    begin
        e00 = 18'(r00); e01 = 18'(r01); e02 = 18'(r02);
        e10 = 18'(r10); e11 = 18'(r11); e12 = 18'(r12);
        e20 = 18'(r20); e21 = 18'(r21); e22 = 18'(r22);
        trace = e00 + e11 + e22;

        // On ties the earlier diagonal element wins, except that r22 beats
        // an equal r00 only when strictly larger.
        priority if (trace > 18'sd0)
            path = PATH_W;
        else if (e00 < e11)
            path = (e11 < e22) ? PATH_Z : PATH_Y;
        else
            path = (e00 < e22) ? PATH_Z : PATH_X;

        unique case (path)
            PATH_W:
            begin
                rsum = trace;
                t0 = e21 - e12; t1 = e02 - e20; t2 = e10 - e01;
            end
            PATH_X:
            begin
                rsum = e00 - e11 - e22;
                t0 = e21 - e12; t1 = e10 + e01; t2 = e20 + e02;
            end
            PATH_Y:
            begin
                rsum = e11 - e22 - e00;
                t0 = e02 - e20; t1 = e21 + e12; t2 = e01 + e10;
            end
            PATH_Z:
            begin
                rsum = e22 - e00 - e11;
                t0 = e10 - e01; t1 = e02 + e20; t2 = e12 + e21;
            end
            default:
            begin
                rsum = trace;
                t0 = '0; t1 = '0; t2 = '0;
            end
        endcase

        rad = 32'(rsum) + ONE_Q;
        ctl_front.invalid = (rad <= 32'sd0);
        ctl_front.path    = path;
        ctl_front.d0      = DIFF_W'(t0);
        ctl_front.d1      = DIFF_W'(t1);
        ctl_front.d2      = DIFF_W'(t2);
        // An invalid radicand is forced to zero; its results are discarded.
        n_front = ctl_front.invalid ? '0 : (NW'(rad[30:0]) << FRAC_BITS);
    end

    logic          front_valid_reg;
    rmq_ctl_t      front_ctl_reg;
    logic [NW-1:0] front_n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            front_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            front_ctl_reg <= ctl_front;
            front_n_reg   <= n_front;
        end
    end

    // ------------------------------------------------------------------
    // Square root chain: one root bit per cell.
    // ------------------------------------------------------------------
    logic          sq_valid [SW+1];
    rmq_ctl_t      sq_ctl   [SW+1];
    logic [NW-1:0] sq_bits  [SW+1];
    logic [SW+1:0] sq_rem   [SW+1];
    logic [SW-1:0] sq_root  [SW+1];

    assign sq_valid[0] = front_valid_reg;
    assign sq_ctl[0]   = front_ctl_reg;
    assign sq_bits[0]  = front_n_reg;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;

    for (genvar c = 0; c < SW; c++)
    begin : g_sqrt
        rmq_sqrt_cell #(
            .SW (SW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sq_valid[c]),
            .in_ctl    (sq_ctl[c]),
            .in_bits   (sq_bits[c]),
            .in_rem    (sq_rem[c]),
            .in_root   (sq_root[c]),
            .out_valid (sq_valid[c+1]),
            .out_ctl   (sq_ctl[c+1]),
            .out_bits  (sq_bits[c+1]),
            .out_rem   (sq_rem[c+1]),
            .out_root  (sq_root[c+1])
        );
    end

    // ------------------------------------------------------------------
    // Divider entry: magnitudes and signs; divisor is 2s.
    // ------------------------------------------------------------------
    logic signed [DIFF_W-1:0] dsel [3];
    logic [DIFF_W-1:0]        dmag [3];

    logic          dv_valid [QW+1];
    rmq_sign_t     dv_sign  [QW+1];
    logic [DW-1:0] dv_div   [QW+1];
    logic [SW-1:0] dv_root  [QW+1];
    logic [DW-1:0] dv_rem   [QW+1][3];
    logic [QW-1:0] dv_qn    [QW+1][3];

    always_comb
    begin
        dsel[0] = sq_ctl[SW].d0;
        dsel[1] = sq_ctl[SW].d1;
        dsel[2] = sq_ctl[SW].d2;
        for (int l = 0; l < 3; l++)
        begin
            dmag[l]        = dsel[l][DIFF_W-1] ? DIFF_W'(-dsel[l]) : DIFF_W'(dsel[l]);
            dv_sign[0].neg[l] = dsel[l][DIFF_W-1];
            dv_rem[0][l]   = '0;
            dv_qn[0][l]    = {dmag[l], {FRAC_BITS{1'b0}}};
        end
        dv_sign[0].invalid = sq_ctl[SW].invalid;
        dv_sign[0].path    = sq_ctl[SW].path;
    end

    assign dv_valid[0] = sq_valid[SW];
    assign dv_div[0]   = {sq_root[SW], 1'b0};
    assign dv_root[0]  = sq_root[SW];

    for (genvar c = 0; c < QW; c++)
    begin : g_div
        rmq_div_cell #(
            .DW (DW),
            .QW (QW),
            .SW (SW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv_valid[c]),
            .in_sign   (dv_sign[c]),
            .in_div    (dv_div[c]),
            .in_root   (dv_root[c]),
            .in_rem    (dv_rem[c]),
            .in_qn     (dv_qn[c]),
            .out_valid (dv_valid[c+1]),
            .out_sign  (dv_sign[c+1]),
            .out_div   (dv_div[c+1]),
            .out_root  (dv_root[c+1]),
            .out_rem   (dv_rem[c+1]),
            .out_qn    (dv_qn[c+1])
        );
    end

    // ------------------------------------------------------------------
    // Output: sign, saturate and place by branch.
    // ------------------------------------------------------------------
    function automatic logic [15:0] sat_mag(input logic [QW-1:0] m);
        logic [15:0] r;
        if (m > QW'(SAT_LIM))
            r = 16'(SAT_LIM);
        else
            r = m[15:0];
        return r;
    endfunction

    logic [15:0]        mag [3];
    logic signed [15:0] qv  [3];
    logic signed [15:0] half;
    logic signed [15:0] x_next, y_next, z_next, w_next;
    rmq_sign_t          fin;

    always_comb
    begin
        fin = dv_sign[QW];
        for (int l = 0; l < 3; l++)
        begin
            mag[l] = sat_mag(dv_qn[QW][l]);
            qv[l]  = fin.neg[l] ? -$signed(mag[l]) : $signed(mag[l]);
        end
        half = $signed(sat_mag(QW'(dv_root[QW] >> 1)));

        unique case (fin.path)
            PATH_W:
            begin
                x_next = qv[0]; y_next = qv[1]; z_next = qv[2]; w_next = half;
            end
            PATH_X:
            begin
                x_next = half; w_next = qv[0]; y_next = qv[1]; z_next = qv[2];
            end
            PATH_Y:
            begin
                y_next = half; w_next = qv[0]; z_next = qv[1]; x_next = qv[2];
            end
            PATH_Z:
            begin
                z_next = half; w_next = qv[0]; x_next = qv[1]; y_next = qv[2];
            end
            default:
            begin
                x_next = '0; y_next = '0; z_next = '0; w_next = '0;
            end
        endcase

        if (fin.invalid)
        begin
            x_next = '0; y_next = '0; z_next = '0; w_next = '0;
        end
    end

    logic               out_valid_reg;
    logic signed [15:0] quat_x_reg, quat_y_reg, quat_z_reg, quat_w_reg;
    logic               invalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quat_x_reg  <= x_next;
            quat_y_reg  <= y_next;
            quat_z_reg  <= z_next;
            quat_w_reg  <= w_next;
            invalid_reg <= fin.invalid;
        end
    end

    assign out_valid = out_valid_reg;
    assign quat_x    = quat_x_reg;
    assign quat_y    = quat_y_reg;
    assign quat_z    = quat_z_reg;
    assign quat_w    = quat_w_reg;
    assign invalid   = invalid_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && invalid) |->
            (quat_x == 16'sd0 && quat_y == 16'sd0 && quat_z == 16'sd0 && quat_w == 16'sd0))
        else $error("invalid result carries nonzero components");

    a_w_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (quat_w <= 16'(SAT_LIM) && quat_w >= -16'(SAT_LIM)))
        else $error("quat_w outside saturation range");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("request taken while the chain is halted");

endmodule

`default_nettype wire

/* sv/rmq_sqrt_cell.sv */
`default_nettype none

// One step of the digit-by-digit floor square root: two radicand bits in,
// one root bit out.
module rmq_sqrt_cell #(
    parameter int SW = 23
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire rmq_pkg::rmq_ctl_t   in_ctl,
    input  wire logic [2*SW-1:0]     in_bits,
    input  wire logic [SW+1:0]       in_rem,
    input  wire logic [SW-1:0]       in_root,
    output logic                     out_valid,
    output rmq_pkg::rmq_ctl_t        out_ctl,
    output logic [2*SW-1:0]          out_bits,
    output logic [SW+1:0]            out_rem,
    output logic [SW-1:0]            out_root
);
    import rmq_pkg::*;

    logic              valid_reg;
    rmq_ctl_t          ctl_reg;
    logic [2*SW-1:0]   bits_reg;
    logic [SW+1:0]     rem_reg;
    logic [SW-1:0]     root_reg;

    logic [SW+3:0]     rem_sh;
    logic [SW+3:0]     trial;
    logic              take;
    logic [SW+1:0]     rem_next;
    logic [SW-1:0]     root_next;
    logic [SW+3:0]     diff;

    always_comb
    begin
        rem_sh    = {in_rem, in_bits[2*SW-1 -: 2]};
        trial     = {2'b00, in_root, 2'b01};
        take      = (rem_sh >= trial);
        diff      = rem_sh - trial;
        rem_next  = take ? diff[SW+1:0] : rem_sh[SW+1:0];
        root_next = {in_root[SW-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg  <= in_ctl;
            bits_reg <= {in_bits[2*SW-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_bits  = bits_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;

endmodule

`default_nettype wire

/* sv/rmq_div_cell.sv */
`default_nettype none

// One restoring division step for three lanes that share a divisor.
// The numerator is shifted out of the top of qn while quotient bits
// enter at the bottom.
module rmq_div_cell #(
    parameter int DW = 24,
    parameter int QW = 31,
    parameter int SW = 23
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire rmq_pkg::rmq_sign_t  in_sign,
    input  wire logic [DW-1:0]       in_div,
    input  wire logic [SW-1:0]       in_root,
    input  wire logic [DW-1:0]       in_rem [3],
    input  wire logic [QW-1:0]       in_qn [3],
    output logic                     out_valid,
    output rmq_pkg::rmq_sign_t       out_sign,
    output logic [DW-1:0]            out_div,
    output logic [SW-1:0]            out_root,
    output logic [DW-1:0]            out_rem [3],
    output logic [QW-1:0]            out_qn [3]
);
    import rmq_pkg::*;

    logic              valid_reg;
    rmq_sign_t         sign_reg;
    logic [DW-1:0]     div_reg;
    logic [SW-1:0]     root_reg;
    logic [DW-1:0]     rem_reg [3];
    logic [QW-1:0]     qn_reg [3];

    logic [DW:0]       rem_sh [3];
    logic [DW:0]       diff [3];
    logic [2:0]        take;
    logic [DW-1:0]     rem_next [3];
    logic [QW-1:0]     qn_next [3];

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            rem_sh[l]   = {in_rem[l], in_qn[l][QW-1]};
            take[l]     = (rem_sh[l] >= {1'b0, in_div});
            diff[l]     = rem_sh[l] - {1'b0, in_div};
            rem_next[l] = take[l] ? diff[l][DW-1:0] : rem_sh[l][DW-1:0];
            qn_next[l]  = {in_qn[l][QW-2:0], take[l]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sign_reg <= in_sign;
            div_reg  <= in_div;
            root_reg <= in_root;
            for (int l = 0; l < 3; l++)
            begin
                rem_reg[l] <= rem_next[l];
                qn_reg[l]  <= qn_next[l];
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_sign  = sign_reg;
    assign out_div   = div_reg;
    assign out_root  = root_reg;
    assign out_rem   = rem_reg;
    assign out_qn    = qn_reg;

endmodule

`default_nettype wire
